[rtl/wsre_pkg.sv]
package wsre_pkg;

   localparam int WINDOW_DEF = 4;
   localparam int WORD_W     = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_PAIR,
      ST_AVG,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      HIST_HOLD,
      HIST_PRESET,
      HIST_ROTATE,
      HIST_SHIFT,
      HIST_LOAD0
   } hist_op_type;

   typedef struct packed {
      hist_op_type         op;
      logic [WORD_W-1:0]   stamp;
      logic [WORD_W-1:0]   value;
   } hist_cmd_type;

endpackage

[rtl/wsre_div.sv]
module wsre_div #(
   parameter int DW = 36
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          long_run,
   input  logic signed [DW-1:0]          dividend,
   input  logic [wsre_pkg::WORD_W-1:0]   divisor,
   output logic                          done,
   output logic signed [DW-1:0]          quotient
);
   import wsre_pkg::*;

   localparam int SHORT_BITS = WORD_W + 1;
   localparam int SHIFT      = DW - SHORT_BITS;
   localparam int CNT_W      = $clog2(DW + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                neg_ff, neg_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [WORD_W-1:0]   rem_ff, rem_in;
   logic [WORD_W-1:0]   dsr_ff, dsr_in;
   logic [DW-1:0]       q_ff, q_in;
   logic signed [DW-1:0] quot_ff, quot_in;

   logic [DW-1:0]       mag;
   logic [WORD_W:0]     trial;
   logic [WORD_W:0]     diff;
   logic                ge;

   always_comb begin
      mag   = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
      trial = {rem_ff, q_ff[DW-1]};
      diff  = trial - {1'b0, dsr_ff};
      ge    = trial >= {1'b0, dsr_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      q_in    = q_ff;
      quot_in = quot_ff;

      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[DW-1];
         rem_in  = '0;
         dsr_in  = divisor;
         q_in    = long_run ? mag : (mag << SHIFT);
         cnt_in  = long_run ? CNT_W'(DW) : CNT_W'(SHORT_BITS);
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quot_in = neg_ff ? DW'(-q_ff) : DW'(q_ff);
         end else begin
            rem_in = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
            q_in   = {q_ff[DW-2:0], ge};
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      q_ff    <= q_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

[rtl/wsre_hist.sv]
module wsre_hist #(
   parameter int WINDOW = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  wsre_pkg::hist_cmd_type        cmd,
   output logic [wsre_pkg::WORD_W-1:0]   time0,
   output logic [wsre_pkg::WORD_W-1:0]   time1,
   output logic [wsre_pkg::WORD_W-1:0]   value0,
   output logic [wsre_pkg::WORD_W-1:0]   value1,
   output logic [wsre_pkg::WORD_W-1:0]   time_prev_last,
   output logic [wsre_pkg::WORD_W-1:0]   time_last
);
   import wsre_pkg::*;

   logic [WORD_W-1:0] time_ff  [WINDOW];
   logic [WORD_W-1:0] time_in  [WINDOW];
   logic [WORD_W-1:0] value_ff [WINDOW];
   logic [WORD_W-1:0] value_in [WINDOW];

   always_comb begin
      for (int i = 0; i < WINDOW; i++) begin
         time_in[i]  = time_ff[i];
         value_in[i] = value_ff[i];
      end
      case (cmd.op)
         HIST_PRESET: begin
            for (int i = 0; i < WINDOW; i++) begin
               time_in[i]  = '0;
               value_in[i] = cmd.value;
            end
         end
         HIST_ROTATE: begin
            for (int i = 0; i < WINDOW - 1; i++) begin
               time_in[i]  = time_ff[i+1];
               value_in[i] = value_ff[i+1];
            end
            time_in[WINDOW-1]  = time_ff[0];
            value_in[WINDOW-1] = value_ff[0];
         end
         HIST_SHIFT: begin
            for (int i = 1; i < WINDOW; i++) begin
               time_in[i]  = time_ff[i-1];
               value_in[i] = value_ff[i-1];
            end
            time_in[0]  = cmd.stamp;
            value_in[0] = cmd.value;
         end
         HIST_LOAD0: begin
            time_in[0]  = cmd.stamp;
            value_in[0] = cmd.value;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            time_ff[i]  <= '0;
            value_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < WINDOW; i++) begin
            time_ff[i]  <= time_in[i];
            value_ff[i] <= value_in[i];
         end
      end
   end

   assign time0          = time_ff[0];
   assign time1          = time_ff[1];
   assign value0         = value_ff[0];
   assign value1         = value_ff[1];
   assign time_prev_last = time_ff[WINDOW-2];
   assign time_last      = time_ff[WINDOW-1];

endmodule

[rtl/windowed_slope_rate_estimator_top.sv]
// channel  ports                                           handshake
// req      req_mode, req_sample_time, req_sample_value     req_valid / req_ready
// rsp      rsp_rate, rsp_updated, rsp_window_full          rsp_valid / rsp_ready
//
// preset or stale word: ST_DONE registers the result once the result register is free, then ST_IDLE takes the next word
// fresh word: ST_DIV divides the newest pair; with a full window each further stored pair is divided in turn
// (skipped if its times do not increase) and ST_AVG then divides the sum by WINDOW
// all divisions run on the single shared bit-serial divider, one quotient bit a cycle
// reset clears the history to zero and empties the result register
// a new word is taken while the previous result still waits on rsp_ready
module windowed_slope_rate_estimator_top #(
   parameter int WINDOW = wsre_pkg::WINDOW_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_mode,
   input  logic [wsre_pkg::WORD_W-1:0]          req_sample_time,
   input  logic signed [wsre_pkg::WORD_W-1:0]   req_sample_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [wsre_pkg::WORD_W-1:0]   rsp_rate,
   output logic                                 rsp_updated,
   output logic                                 rsp_window_full
);
   import wsre_pkg::*;

   localparam int SUM_W = WORD_W + 2 + $clog2(WINDOW);
   localparam int CW    = $clog2(WINDOW);
   localparam logic [CW-1:0] PAIR_LAST = CW'(WINDOW - 1);
   localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sh7FFF_FFFF);
   localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(64'sh8000_0000);

   state_type            state_ff, state_in;
   logic [WORD_W-1:0]    t_ff, t_in;
   logic [WORD_W-1:0]    v_ff, v_in;
   logic                 full_ff, full_in;
   logic                 upd_ff, upd_in;
   hist_op_type          commit_ff, commit_in;
   logic [CW-1:0]        pair_cnt_ff, pair_cnt_in;
   logic signed [SUM_W-1:0] acc_ff, acc_in;
   logic signed [SUM_W-1:0] res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_W-1:0] rsp_rate_ff, rsp_rate_in;
   logic                 rsp_updated_ff, rsp_updated_in;
   logic                 rsp_full_ff, rsp_full_in;

   hist_cmd_type         hcmd;
   logic [WORD_W-1:0]    h_t0, h_t1, h_v0, h_v1, h_tpl, h_tl;

   logic                 div_start, div_long, div_done;
   logic signed [SUM_W-1:0] div_dividend, div_quot;
   logic [WORD_W-1:0]    div_divisor;

   logic [WORD_W-1:0]    pn_t, pn_v, po_t, po_v;
   logic signed [WORD_W:0] dv;
   logic signed [SUM_W-1:0] acc_sum;
   logic signed [WORD_W-1:0] sat_rate;

   wsre_hist #(.WINDOW(WINDOW)) u_hist (
      .clock          (clock),
      .reset          (reset),
      .cmd            (hcmd),
      .time0          (h_t0),
      .time1          (h_t1),
      .value0         (h_v0),
      .value1         (h_v1),
      .time_prev_last (h_tpl),
      .time_last      (h_tl)
   );

   wsre_div #(.DW(SUM_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .long_run (div_long),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      if (res_ff > SAT_MAX) begin
         sat_rate = WORD_W'(SAT_MAX);
      end else if (res_ff < SAT_MIN) begin
         sat_rate = WORD_W'(SAT_MIN);
      end else begin
         sat_rate = WORD_W'(res_ff);
      end
   end

   always_comb begin
      if (state_ff == ST_IDLE) begin
         pn_t = req_sample_time;
         pn_v = req_sample_value;
      end else begin
         pn_t = h_t0;
         pn_v = h_v0;
      end
      po_t = (state_ff == ST_IDLE) ? h_t0 : h_t1;
      po_v = (state_ff == ST_IDLE) ? h_v0 : h_v1;
      dv      = $signed({pn_v[WORD_W-1], pn_v}) - $signed({po_v[WORD_W-1], po_v});
      acc_sum = acc_ff + div_quot;

      state_in       = state_ff;
      t_in           = t_ff;
      v_in           = v_ff;
      full_in        = full_ff;
      upd_in         = upd_ff;
      commit_in      = commit_ff;
      pair_cnt_in    = pair_cnt_ff;
      acc_in         = acc_ff;
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_rate_in    = rsp_rate_ff;
      rsp_updated_in = rsp_updated_ff;
      rsp_full_in    = rsp_full_ff;
      req_ready      = 1'b0;
      div_start      = 1'b0;
      div_long       = 1'b0;
      div_dividend   = {{(SUM_W-WORD_W-1){dv[WORD_W]}}, dv};
      div_divisor    = pn_t - po_t;
      hcmd.op        = HIST_HOLD;
      hcmd.stamp     = t_ff;
      hcmd.value     = v_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               t_in        = req_sample_time;
               v_in        = req_sample_value;
               acc_in      = '0;
               res_in      = '0;
               pair_cnt_in = '0;
               if (req_mode) begin
                  upd_in    = 1'b0;
                  full_in   = 1'b0;
                  commit_in = HIST_PRESET;
                  state_in  = ST_DONE;
               end else if (req_sample_time <= h_t0) begin
                  upd_in    = 1'b0;
                  full_in   = 1'b0;
                  commit_in = HIST_HOLD;
                  state_in  = ST_DONE;
               end else begin
                  upd_in    = 1'b1;
                  full_in   = h_tpl > h_tl;
                  commit_in = (h_tpl > h_tl) ? HIST_LOAD0 : HIST_SHIFT;
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               acc_in = acc_sum;
               if (!full_ff) begin
                  res_in   = acc_sum;
                  state_in = ST_DONE;
               end else if (pair_cnt_ff == PAIR_LAST) begin
                  div_start    = 1'b1;
                  div_long     = 1'b1;
                  div_dividend = acc_sum;
                  div_divisor  = WORD_W'(WINDOW);
                  state_in     = ST_AVG;
               end else begin
                  state_in = ST_PAIR;
               end
            end
         end
         ST_PAIR: begin
            hcmd.op     = HIST_ROTATE;
            pair_cnt_in = pair_cnt_ff + CW'(1);
            if (h_t0 > h_t1) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else if (pair_cnt_in == PAIR_LAST) begin
               div_start    = 1'b1;
               div_long     = 1'b1;
               div_dividend = acc_ff;
               div_divisor  = WORD_W'(WINDOW);
               state_in     = ST_AVG;
            end
         end
         ST_AVG: begin
            if (div_done) begin
               res_in   = div_quot;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               hcmd.op        = commit_ff;
               rsp_valid_in   = 1'b1;
               rsp_rate_in    = sat_rate;
               rsp_updated_in = upd_ff;
               rsp_full_in    = upd_ff && full_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pair_cnt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pair_cnt_ff  <= pair_cnt_in;
      end
      t_ff           <= t_in;
      v_ff           <= v_in;
      full_ff        <= full_in;
      upd_ff         <= upd_in;
      commit_ff      <= commit_in;
      acc_ff         <= acc_in;
      res_ff         <= res_in;
      rsp_rate_ff    <= rsp_rate_in;
      rsp_updated_ff <= rsp_updated_in;
      rsp_full_ff    <= rsp_full_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rate        = rsp_rate_ff;
   assign rsp_updated     = rsp_updated_ff;
   assign rsp_window_full = rsp_full_ff;

   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV || state_ff == ST_AVG))
      else $error("divider finished outside a wait state");

   a_full_needs_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_full_ff |-> rsp_updated_ff)
      else $error("window full flagged on a word that was not stored");

   a_idle_rate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_updated_ff |-> rsp_rate_ff == '0)
      else $error("nonzero rate on a word that was not stored");

   a_pair_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PAIR |-> pair_cnt_ff < PAIR_LAST)
      else $error("pair walk overran the window");

endmodule
